FILE: hdl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared constants, types and the CRC-16 byte update for the command frame
// CRC-16 framer.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 4;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam int unsigned MAX_RESULTS = 3;

  // operation codes
  localparam logic OP_TX = 1'b0;
  localparam logic OP_RX = 1'b1;

  // result bundle produced for one input beat
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;  // emitted in order from index 0
    logic [1:0]                  count;  // number of results, 1 or 3
    logic                        last;   // final result closes the frame
    logic                        ok;     // crc_ok on the final result
  } res_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/cfc_in_if.sv
// ----------------------------------------------------------------------------
// cfc_in_if
// Input channel: frame bytes with last mark and operation.
// ----------------------------------------------------------------------------
interface cfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       operation;

  modport source (output valid, data_byte, last_byte, operation, input ready);
  modport sink   (input valid, data_byte, last_byte, operation, output ready);
endinterface

FILE: hdl/cfc_out_if.sv
// ----------------------------------------------------------------------------
// cfc_out_if
// Output channel: frame bytes, appended crc bytes and check status.
// ----------------------------------------------------------------------------
interface cfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       crc_ok;

  modport source (output valid, out_byte, out_last, crc_ok, input ready);
  modport sink   (input valid, out_byte, out_last, crc_ok, output ready);
endinterface

FILE: hdl/command_frame_crc16_framer.sv
// ----------------------------------------------------------------------------
// command_frame_crc16_framer
// Passes command frame bytes through and appends or checks a reflected
// CRC-16 (poly 0xA001, start 0xFFFF) over the bytes after the header.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one frame byte per beat with last_byte on the final byte and
//   operation selecting transmit (append crc) or receive (check crc).
//   out_o carries the bytes back out; a transmit frame longer than the header
//   gets two more beats, crc low byte then high byte. On a receive frame the
//   final beat reports crc_ok.
//   A beat accepted on in_i passes the input register and then the result
//   register before it shows on out_o.
//   Throughput: one beat per cycle while out_o is ready; a transmit final byte
//   with crc occupies the result register for three output beats, set by the
//   single result register draining one byte per cycle.
//   Reset clears the frame state (crc to 0xFFFF, position and held bytes to
//   zero) and empties both registers. When out_o stalls, results hold in the
//   result register, one more beat waits in the input register, and in_i
//   ready then drops.
// ----------------------------------------------------------------------------
module command_frame_crc16_framer import cfc_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfc_in_if.sink    in_i,
  cfc_out_if.source out_o
);

  logic res_valid;
  logic buf_free;
  res_t res;

  cfc_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .buf_free_i  (buf_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfc_out_seq u_out_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .load_i       (res),
    .free_o       (buf_free),
    .out_o        (out_o)
  );

endmodule

FILE: hdl/cfc_core.sv
// ----------------------------------------------------------------------------
// cfc_core
// Input register, frame state (crc, position, held bytes) and the single
// pass logic that turns one registered beat into its result bundle.
// ----------------------------------------------------------------------------
module cfc_core import cfc_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cfc_in_if.sink   in_i,
  input  logic     buf_free_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  localparam int unsigned PosLimit = HEADER_BYTES + 2;
  localparam int unsigned PosW     = $clog2(PosLimit + 1);

  localparam logic [PosW-1:0] PosHdr = PosW'(HEADER_BYTES);
  localparam logic [PosW-1:0] PosMax = PosW'(PosLimit);

  // input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_last_q;
  logic       a_op_q;

  // frame state
  logic [15:0]     crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      held0_q, held0_d, held1_q, held1_d;

  logic        advance;
  logic        feed_en;
  logic [7:0]  feed_byte;
  logic [15:0] crc_fed;
  logic        past_hdr;

  assign advance    = a_valid_q && buf_free_i;
  assign in_i.ready = !a_valid_q || buf_free_i;

  assign past_hdr  = (pos_q >= PosHdr);
  // receive bytes enter the crc two beats late so the trailing crc stays out
  assign feed_byte = (a_op_q == OP_RX) ? held0_q : a_byte_q;
  assign feed_en   = (a_op_q == OP_RX) ? (pos_q >= PosMax) : past_hdr;
  assign crc_fed   = feed_en ? crc16_feed(crc_q, feed_byte) : crc_q;

  always_comb begin
    res_o       = '0;
    res_o.bytes[0] = a_byte_q;
    res_o.count = 2'd1;
    crc_d   = crc_fed;
    pos_d   = (pos_q < PosMax) ? pos_q + 1'b1 : pos_q;
    held0_d = held1_q;
    held1_d = a_byte_q;
    if (a_last_q) begin
      res_o.last = 1'b1;
      if (a_op_q == OP_TX) begin
        if (past_hdr) begin
          res_o.bytes[1] = crc_fed[7:0];
          res_o.bytes[2] = crc_fed[15:8];
          res_o.count    = 2'd3;
        end
      end else begin
        if (pos_q < PosHdr) begin
          res_o.ok = 1'b1;
        end else if (pos_q == PosHdr) begin
          res_o.ok = 1'b0;
        end else begin
          res_o.ok = ({a_byte_q, held1_q} == crc_fed);
        end
      end
      crc_d   = CRC_START;
      pos_d   = '0;
      held0_d = '0;
      held1_d = '0;
    end
  end

  assign res_valid_o = a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      crc_q     <= CRC_START;
      pos_q     <= '0;
      held0_q   <= '0;
      held1_q   <= '0;
    end else begin
      if (in_i.ready) begin
        a_valid_q <= in_i.valid;
      end
      if (advance) begin
        crc_q   <= crc_d;
        pos_q   <= pos_d;
        held0_q <= held0_d;
        held1_q <= held1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      a_byte_q <= in_i.data_byte;
      a_last_q <= in_i.last_byte;
      a_op_q   <= in_i.operation;
    end
  end

endmodule

FILE: hdl/cfc_out_seq.sv
// ----------------------------------------------------------------------------
// cfc_out_seq
// Result register: holds one result bundle and hands its beats out one per
// cycle on the output channel while the channel is ready.
// ----------------------------------------------------------------------------
module cfc_out_seq import cfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_valid_i,
  input  res_t      load_i,
  output logic      free_o,
  cfc_out_if.source out_o
);

  res_t       res_q;
  logic [1:0] rem_q, rem_d;
  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       load;

  assign fire   = out_o.valid && out_o.ready;
  // free next cycle if empty or the final beat leaves now
  assign free_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_o.ready);
  assign load   = load_valid_i && free_o;

  assign out_o.valid    = (rem_q != 2'd0);
  assign out_o.out_byte = res_q.bytes[idx_q];
  assign out_o.out_last = res_q.last && (rem_q == 2'd1);
  assign out_o.crc_ok   = res_q.ok && (rem_q == 2'd1);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load) begin
      rem_d = load_i.count;
      idx_d = '0;
    end else if (fire) begin
      rem_d = rem_q - 1'b1;
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= load_i;
    end
  end

endmodule
